/* rtl/csvfs_pkg.sv */
// csvfs_pkg: types and constants shared by the CSV field splitter.
// No dependencies; compiled first.
package csvfs_pkg;

   localparam int FLEN_W = 16;

   localparam logic [FLEN_W-1:0] MAX_FIELD_LEN = 16'd65535;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } csvfs_req_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] out_char;
      logic       field_end;
      logic       row_end;
      logic       no_row;
      logic       overflow;
   } csvfs_rsp_type;

   typedef struct packed {
      logic              held_valid;
      logic [7:0]        held_char;
      logic [FLEN_W-1:0] field_length;
      logic              in_quotes;
      logic              last_was_quote;
      logic              quote_run_odd;
      logic              row_has_fields;
   } csvfs_state_type;

endpackage

/* rtl/csvfs_if.sv */
// csvfs_if: valid/ready channels for input items and result items.
// No dependencies.
interface csvfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] out_char;
   logic       field_end;
   logic       row_end;
   logic       no_row;
   logic       overflow;

   modport source (output valid, output char_valid, output out_char, output field_end,
                   output row_end, output no_row, output overflow, input ready);
   modport sink   (input valid, input char_valid, input out_char, input field_end,
                   input row_end, input no_row, input overflow, output ready);
endinterface

/* rtl/csv_field_splitter.sv */
// csv_field_splitter: top level of the CSV field and row splitter.
// Depends on csvfs_pkg, csvfs_if and csvfs_step.
//
// Takes one character (or an end-of-input mark) per clock and returns at most
// one result item per input item. An accepted item sits in an input register,
// the quote and field logic in csvfs_step updates the parser state and writes
// the result register when the item advances, so a result is offered from the
// result register after its item has left the input register. Throughput is
// one item per clock while the result side keeps ready high; a stall on the
// result side backs up through the input register. Items that yield no
// result (carriage returns, opening quotes, characters going into the holding
// register) still pass through the input register. Field characters are
// delayed by one kept character so a closing quote can be withdrawn.
module csv_field_splitter (
   input logic   clock,
   input logic   reset,
   csvfs_req_if.sink   req_chan,
   csvfs_rsp_if.source rsp_chan
);
   import csvfs_pkg::*;

   logic            in_valid_ff, in_valid_in;
   csvfs_req_type   in_item_ff, in_item_in;
   logic            out_valid_ff, out_valid_in;
   csvfs_rsp_type   out_item_ff, out_item_in;
   csvfs_state_type st_ff, st_in;

   csvfs_state_type st_calc;
   csvfs_rsp_type   rsp_calc;
   logic            has_rsp;
   logic            advance;
   logic            req_take;

   csvfs_step u_step (
      .st_cur  (st_ff),
      .item    (in_item_ff),
      .st_nxt  (st_calc),
      .has_rsp (has_rsp),
      .rsp     (rsp_calc)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = req_take ? csvfs_req_type'{req_chan.in_byte, req_chan.end_of_input}
                              : in_item_ff;
      out_valid_in = advance ? has_rsp : (out_valid_ff && !rsp_chan.ready);
      out_item_in  = (advance && has_rsp) ? rsp_calc : out_item_ff;
      st_in        = advance ? st_calc : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         st_ff        <= st_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.char_valid = out_item_ff.char_valid;
   assign rsp_chan.out_char   = out_item_ff.out_char;
   assign rsp_chan.field_end  = out_item_ff.field_end;
   assign rsp_chan.row_end    = out_item_ff.row_end;
   assign rsp_chan.no_row     = out_item_ff.no_row;
   assign rsp_chan.overflow   = out_item_ff.overflow;

   a_held_has_length: assert property (@(posedge clock) disable iff (reset)
      st_ff.held_valid |-> st_ff.field_length != '0)
      else $error("held character with zero field length");

   a_row_end_ends_field: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.row_end |-> rsp_chan.field_end && !rsp_chan.no_row)
      else $error("row end without field end");

   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.overflow |-> !rsp_chan.char_valid && !rsp_chan.field_end)
      else $error("overflow item carries other content");

   a_field_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && has_rsp && rsp_calc.field_end |=> st_ff.field_length == '0 && !st_ff.held_valid)
      else $error("field state not cleared after field end");

endmodule

/* rtl/csvfs_step.sv */
// csvfs_step: next-state and result logic for one item of the splitter.
// Depends on csvfs_pkg.
module csvfs_step (
   input  csvfs_pkg::csvfs_state_type st_cur,
   input  csvfs_pkg::csvfs_req_type   item,
   output csvfs_pkg::csvfs_state_type st_nxt,
   output logic                       has_rsp,
   output csvfs_pkg::csvfs_rsp_type   rsp
);
   import csvfs_pkg::*;

   logic [7:0] c;
   logic       eof;
   logic       is_quote;
   logic       rel;
   logic       row_end;

   always_comb begin
      st_nxt   = st_cur;
      has_rsp  = 1'b0;
      rsp      = '0;
      eof      = item.end_of_input;
      c        = eof ? CH_NL : item.in_byte;
      is_quote = (c == CH_QUOTE);
      rel      = 1'b0;
      row_end  = (c == CH_NL);

      if (eof && st_cur.field_length == '0 && !st_cur.row_has_fields) begin
         // empty end of input: drop any lone opening quote
         st_nxt.held_valid     = 1'b0;
         st_nxt.in_quotes      = 1'b0;
         st_nxt.last_was_quote = 1'b0;
         st_nxt.quote_run_odd  = 1'b0;
         has_rsp               = 1'b1;
         rsp.no_row            = 1'b1;
      end else if (!eof && c == CH_CR) begin
         // carriage return: consumed
      end else if (st_cur.field_length == '0 && !st_cur.last_was_quote && is_quote) begin
         st_nxt.in_quotes      = 1'b1;
         st_nxt.last_was_quote = 1'b1;
      end else begin
         if (st_cur.field_length != '0 || st_cur.last_was_quote) begin
            if (is_quote) begin
               st_nxt.quote_run_odd = ~st_cur.quote_run_odd;
               st_nxt.in_quotes     = st_cur.quote_run_odd;
               // second quote of a pair withdraws the held one
               if (st_cur.quote_run_odd && st_cur.held_valid) begin
                  st_nxt.held_valid   = 1'b0;
                  st_nxt.field_length = st_cur.field_length - FLEN_W'(1);
               end
            end else begin
               st_nxt.quote_run_odd = 1'b0;
            end
         end

         if (eof || (!st_nxt.in_quotes && (c == CH_NL || c == CH_COMMA))) begin
            rel               = st_nxt.held_valid && !st_cur.last_was_quote;
            has_rsp           = 1'b1;
            rsp.char_valid    = rel;
            rsp.out_char      = rel ? st_cur.held_char : 8'h00;
            rsp.field_end     = 1'b1;
            rsp.row_end       = row_end;
            st_nxt.held_valid     = 1'b0;
            st_nxt.field_length   = '0;
            st_nxt.in_quotes      = 1'b0;
            st_nxt.last_was_quote = 1'b0;
            st_nxt.quote_run_odd  = 1'b0;
            st_nxt.row_has_fields = !row_end;
         end else begin
            st_nxt.last_was_quote = is_quote;
            if (st_nxt.field_length >= MAX_FIELD_LEN) begin
               has_rsp      = 1'b1;
               rsp.overflow = 1'b1;
            end else begin
               if (st_nxt.held_valid) begin
                  has_rsp        = 1'b1;
                  rsp.char_valid = 1'b1;
                  rsp.out_char   = st_cur.held_char;
               end
               st_nxt.held_char    = c;
               st_nxt.held_valid   = 1'b1;
               st_nxt.field_length = st_nxt.field_length + FLEN_W'(1);
            end
         end
      end
   end

endmodule
